### hdl/bytecode_instruction_framer_assert.svh
// Assertion macros shared by the framer modules.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BYTECODE_INSTRUCTION_FRAMER_ASSERT_SVH
`define BYTECODE_INSTRUCTION_FRAMER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BIF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("framer assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BIF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("framer assertion failed");

`endif

### hdl/bif_pkg.sv
package bif_pkg;

  // Header layout.
  localparam logic [31:0] HDR_LEN     = 32'd13;
  localparam logic [7:0]  BYTE_N      = 8'h4E;
  localparam logic [7:0]  BYTE_C      = 8'h43;
  localparam logic [7:0]  BYTE_B      = 8'h42;
  localparam logic [31:0] POS_MAGIC_END = 32'd7;
  localparam logic [31:0] POS_SIZE_TAG  = 32'd8;
  localparam logic [31:0] POS_HDR_END   = 32'd12;

  // Valid opcode range.
  localparam logic [7:0] OP_FIRST = 8'h01;
  localparam logic [7:0] OP_LAST  = 8'h2D;

  // Configuration port.
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_ALLOW_PARTIAL = 1'b0;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_INSTR  = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_EMPTY         = 3'd1,
    ERR_TRUNC_HDR     = 3'd2,
    ERR_BAD_HDR       = 3'd3,
    ERR_TRUNC_INSTR   = 3'd4,
    ERR_BAD_OPCODE    = 3'd5,
    ERR_TRUNC_STRLEN  = 3'd6,
    ERR_TRUNC_OPERAND = 3'd7
  } err_t;

  typedef enum logic [6:0] {
    PH_FIRST   = 7'b0000001,
    PH_MAGIC   = 7'b0000010,
    PH_HDR     = 7'b0000100,
    PH_OPCODE  = 7'b0001000,
    PH_AUX     = 7'b0010000,
    PH_STRLEN  = 7'b0100000,
    PH_OPERAND = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    err_t               error_code;
    logic               success;
    logic [31:0]        file_offset;
    logic [31:0]        code_offset;
    logic [7:0]         opcode;
    logic [7:0]         aux;
    logic [16:0]        extra_len;
    logic [31:0]        operand_first;
    logic [31:0]        operand_second;
    logic signed [33:0] jump_target;
    logic               last_of_run;
  } result_t;

  // Writes from the parser into the result queue: zero, one or two results.
  typedef struct packed {
    logic [1:0] count;
    result_t    slot0;
    result_t    slot1;
  } queue_wr_t;

  // Operand length of an opcode/aux pair; str marks a length-prefixed string.
  typedef struct packed {
    logic       str;
    logic [3:0] len;
  } op_len_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h4E;
      3'd1:    v = 8'h43;
      3'd2:    v = 8'h53;
      3'd3:    v = 8'h20;
      3'd4:    v = 8'h56;
      3'd5:    v = 8'h31;
      3'd6:    v = 8'h2E;
      default: v = 8'h30;
    endcase
    return v;
  endfunction

  function automatic op_len_t operand_size(input logic [7:0] op, input logic [7:0] aux);
    op_len_t r;
    r = '0;
    case (op)
      8'h04: begin
        if (aux inside {8'h03, 8'h04, 8'h06, 8'h12}) r.len = 4'd4;
        else if (aux inside {8'h05, 8'h17}) r.str = 1'b1;
      end
      8'h1D, 8'h1E, 8'h1F, 8'h25, 8'h1B, 8'h23, 8'h24, 8'h28, 8'h29: r.len = 4'd4;
      8'h2C: r.len = 4'd8;
      8'h05: r.len = 4'd3;
      8'h03, 8'h27, 8'h01, 8'h26, 8'h21: r.len = 4'd6;
      8'h0B, 8'h0C: r.len = (aux == 8'h24) ? 4'd2 : 4'd0;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic is_jump(input logic [7:0] op);
    return op inside {8'h1D, 8'h1E, 8'h1F, 8'h25};
  endfunction

  function automatic result_t make_error(input err_t code, input logic [31:0] foff,
                                         input logic [31:0] coff, input logic [7:0] op,
                                         input logic [7:0] aux);
    result_t r;
    r = '0;
    r.kind        = KIND_ERROR;
    r.error_code  = code;
    r.file_offset = foff;
    r.code_offset = coff;
    r.opcode      = op;
    r.aux         = aux;
    return r;
  endfunction

endpackage

### hdl/bif_stream_if.sv
interface bif_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output has_byte, output end_of_file,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input end_of_file,
                  output ready);
endinterface

### hdl/bif_result_if.sv
interface bif_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [2:0]         error_code;
  logic               success;
  logic [31:0]        file_offset;
  logic [31:0]        code_offset;
  logic [7:0]         opcode;
  logic [7:0]         aux;
  logic [16:0]        extra_len;
  logic [31:0]        operand_first;
  logic [31:0]        operand_second;
  logic signed [33:0] jump_target;
  logic               last_of_run;

  modport source (output valid, output kind, output error_code, output success,
                  output file_offset, output code_offset, output opcode, output aux,
                  output extra_len, output operand_first, output operand_second,
                  output jump_target, output last_of_run, input ready);
  modport sink   (input valid, input kind, input error_code, input success,
                  input file_offset, input code_offset, input opcode, input aux,
                  input extra_len, input operand_first, input operand_second,
                  input jump_target, input last_of_run, output ready);
endinterface

### hdl/bytecode_instruction_framer.sv
// Channel   Direction  Transfer carries
// stream    in         one file byte (data_byte, has_byte, end_of_file)
// result    out        one header, instruction, error or end status record
// APB       in/out     allow_partial at address 0
//
// One byte is taken per cycle while stream.ready is high; each byte yields zero, one or two results.
// A byte is held in the input register until the queue has room, then is parsed
// and its results enter a QUEUE_DEPTH-entry result queue.
// stream.ready drops while a byte waits in the input register and the queue
// has fewer than two free entries.
// Reset (rst, synchronous) returns the framer to the start of a file and
// clears allow_partial.
module bytecode_instruction_framer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  bif_stream_if.sink                  stream,
  bif_result_if.source                result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bif_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic               allow_partial;
  logic               room;
  bif_pkg::queue_wr_t wr;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      allow_partial <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == bif_pkg::REG_ALLOW_PARTIAL) begin
      allow_partial <= pwdata[0];
    end
  end
  assign prdata = (paddr[2] == bif_pkg::REG_ALLOW_PARTIAL) ? {31'd0, allow_partial} : 32'd0;

  bif_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .stream        (stream),
    .allow_partial (allow_partial),
    .room          (room),
    .wr            (wr)
  );

  bif_result_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .room   (room),
    .result (result)
  );

endmodule

### hdl/bif_parser.sv
module bif_parser (
  input  logic                clk,
  input  logic                rst,
  bif_stream_if.sink          stream,
  input  logic                allow_partial,
  input  logic                room,
  output bif_pkg::queue_wr_t  wr
);

  // Input register.
  bif_pkg::item_t  in_q;
  logic            in_q_valid;
  logic            fire;

  // Framing state.
  logic [31:0]     byte_position, byte_position_next;
  bif_pkg::phase_t phase, phase_next;
  logic            header_seen, header_seen_next;
  logic            bad_header_pending, bad_header_pending_next;
  logic [31:0]     instr_start, instr_start_next;
  logic [31:0]     instr_code, instr_code_next;
  logic [7:0]      cur_opcode, cur_opcode_next;
  logic [7:0]      cur_aux, cur_aux_next;
  logic [16:0]     operand_needed, operand_needed_next;
  logic [16:0]     operand_count, operand_count_next;
  logic [63:0]     operand_shift, operand_shift_next;
  logic            failed, failed_next;
  logic            any_emitted, any_emitted_next;
  bif_pkg::err_t   err_code, err_code_next;

  // Results of one item.
  bif_pkg::result_t cons_res, fin_res, end_res;
  logic             cons_v, fin_v, emit;
  bif_pkg::op_len_t op_len;
  logic [7:0]       b;
  logic [31:0]      jump_first;
  bif_pkg::err_t    err_final;
  logic             failed_final;
  logic [1:0]       n_res;

  assign fire         = in_q_valid && room;
  assign stream.ready = !in_q_valid || fire;
  assign b            = in_q.data_byte;

  // Input register holds one item until the queue has room for its results.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (stream.ready) begin
      in_q_valid <= stream.valid;
    end
    if (stream.ready && stream.valid) begin
      in_q.data_byte   <= stream.data_byte;
      in_q.has_byte    <= stream.has_byte;
      in_q.end_of_file <= stream.end_of_file;
    end
  end

  // Byte consumption, end-of-file handling and result selection.
  always_comb begin
    byte_position_next      = byte_position;
    phase_next              = phase;
    header_seen_next        = header_seen;
    bad_header_pending_next = bad_header_pending;
    instr_start_next        = instr_start;
    instr_code_next         = instr_code;
    cur_opcode_next         = cur_opcode;
    cur_aux_next            = cur_aux;
    operand_needed_next     = operand_needed;
    operand_count_next      = operand_count;
    operand_shift_next      = operand_shift;
    failed_next             = failed;
    any_emitted_next        = any_emitted;
    err_code_next           = err_code;
    cons_res                = '0;
    cons_v                  = 1'b0;
    emit                    = 1'b0;
    op_len                  = '0;

    if (in_q.has_byte && !failed) begin
      case (phase)
        bif_pkg::PH_FIRST: begin
          if (b == bif_pkg::BYTE_N) begin
            phase_next = bif_pkg::PH_MAGIC;
          end else begin
            instr_start_next = '0;
            instr_code_next  = '0;
            cur_opcode_next  = b;
            phase_next       = bif_pkg::PH_AUX;
          end
        end
        bif_pkg::PH_MAGIC: begin
          if (b != bif_pkg::magic_byte(byte_position[2:0])) begin
            // Not a header after all: the leading byte is an unknown opcode.
            cons_v        = 1'b1;
            cons_res      = bif_pkg::make_error(bif_pkg::ERR_BAD_OPCODE, '0, '0,
                              bif_pkg::BYTE_N,
                              (byte_position == 32'd1) ? b : bif_pkg::BYTE_C);
            failed_next   = 1'b1;
            err_code_next = bif_pkg::ERR_BAD_OPCODE;
          end else if (byte_position == bif_pkg::POS_MAGIC_END) begin
            phase_next         = bif_pkg::PH_HDR;
            operand_shift_next = '0;
          end
        end
        bif_pkg::PH_HDR: begin
          if (byte_position == bif_pkg::POS_SIZE_TAG) begin
            if (b != bif_pkg::BYTE_B) bad_header_pending_next = 1'b1;
          end else begin
            operand_shift_next = {32'd0, operand_shift[23:0], b};
          end
          if (byte_position == bif_pkg::POS_HDR_END) begin
            if (bad_header_pending_next) begin
              cons_v        = 1'b1;
              cons_res      = bif_pkg::make_error(bif_pkg::ERR_BAD_HDR,
                                bif_pkg::POS_SIZE_TAG, '0, '0, '0);
              failed_next   = 1'b1;
              err_code_next = bif_pkg::ERR_BAD_HDR;
            end else begin
              cons_v                 = 1'b1;
              cons_res.kind          = bif_pkg::KIND_HEADER;
              cons_res.operand_first = operand_shift_next[31:0];
              header_seen_next       = 1'b1;
              operand_shift_next     = '0;
              phase_next             = bif_pkg::PH_OPCODE;
            end
          end
        end
        bif_pkg::PH_OPCODE: begin
          instr_start_next = byte_position;
          instr_code_next  = byte_position - (header_seen ? bif_pkg::HDR_LEN : 32'd0);
          cur_opcode_next  = b;
          phase_next       = bif_pkg::PH_AUX;
        end
        bif_pkg::PH_AUX: begin
          cur_aux_next = b;
          if (!(cur_opcode inside {[bif_pkg::OP_FIRST:bif_pkg::OP_LAST]})) begin
            cons_v        = 1'b1;
            cons_res      = bif_pkg::make_error(bif_pkg::ERR_BAD_OPCODE, instr_start,
                              instr_code, cur_opcode, b);
            failed_next   = 1'b1;
            err_code_next = bif_pkg::ERR_BAD_OPCODE;
          end else begin
            operand_count_next = '0;
            operand_shift_next = '0;
            op_len             = bif_pkg::operand_size(cur_opcode, b);
            if (op_len.str) begin
              operand_needed_next = 17'd2;
              phase_next          = bif_pkg::PH_STRLEN;
            end else begin
              operand_needed_next = {13'd0, op_len.len};
              if (op_len.len == 4'd0) emit = 1'b1;
              else phase_next = bif_pkg::PH_OPERAND;
            end
          end
        end
        bif_pkg::PH_STRLEN: begin
          operand_shift_next[{3'd7 - operand_count[2:0], 3'b000} +: 8] = b;
          operand_count_next = operand_count + 17'd1;
          if (operand_count_next == 17'd2) begin
            operand_needed_next = 17'd2 + {1'b0, operand_shift_next[63:48]};
            if (operand_needed_next == operand_count_next) emit = 1'b1;
            else phase_next = bif_pkg::PH_OPERAND;
          end
        end
        bif_pkg::PH_OPERAND: begin
          // Only the first eight operand bytes, length prefix included, are kept; string bytes past them are skipped.
          if (operand_count[16:3] == 14'd0) begin
            operand_shift_next[{3'd7 - operand_count[2:0], 3'b000} +: 8] = b;
          end
          operand_count_next = operand_count + 17'd1;
          if (operand_count_next >= operand_needed) emit = 1'b1;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end

    // Completed instruction.
    jump_first = operand_shift_next[63:32];
    if (emit) begin
      cons_v                  = 1'b1;
      cons_res.kind           = bif_pkg::KIND_INSTR;
      cons_res.file_offset    = instr_start_next;
      cons_res.code_offset    = instr_code_next;
      cons_res.opcode         = cur_opcode_next;
      cons_res.aux            = cur_aux_next;
      cons_res.extra_len      = operand_needed_next;
      cons_res.operand_first  = jump_first;
      cons_res.operand_second = operand_shift_next[31:0];
      if (bif_pkg::is_jump(cur_opcode_next)) begin
        cons_res.jump_target = $signed({2'b00, instr_code_next}
                                       + {{2{jump_first[31]}}, jump_first});
      end
      any_emitted_next = 1'b1;
      phase_next       = bif_pkg::PH_OPCODE;
    end

    if (in_q.has_byte) byte_position_next = byte_position + 32'd1;

    // Error for a file that is empty or ends in the middle of something.
    fin_res = '0;
    fin_v   = 1'b0;
    if (in_q.end_of_file && !failed_next) begin
      fin_v = 1'b1;
      case (phase_next)
        bif_pkg::PH_FIRST:
          fin_res = bif_pkg::make_error(bif_pkg::ERR_EMPTY, '0, '0, '0, '0);
        bif_pkg::PH_MAGIC: begin
          if (byte_position_next == 32'd1) begin
            fin_res = bif_pkg::make_error(bif_pkg::ERR_TRUNC_INSTR, '0, '0, '0, '0);
          end else begin
            fin_res = bif_pkg::make_error(bif_pkg::ERR_BAD_OPCODE, '0, '0,
                                          bif_pkg::BYTE_N, bif_pkg::BYTE_C);
          end
        end
        bif_pkg::PH_HDR:
          fin_res = bif_pkg::make_error(bif_pkg::ERR_TRUNC_HDR, '0, '0, '0, '0);
        bif_pkg::PH_AUX:
          fin_res = bif_pkg::make_error(bif_pkg::ERR_TRUNC_INSTR, instr_start_next,
                                        instr_code_next, '0, '0);
        bif_pkg::PH_STRLEN:
          fin_res = bif_pkg::make_error(bif_pkg::ERR_TRUNC_STRLEN, instr_start_next,
                                        instr_code_next, cur_opcode_next, cur_aux_next);
        bif_pkg::PH_OPERAND:
          fin_res = bif_pkg::make_error(bif_pkg::ERR_TRUNC_OPERAND, instr_start_next,
                                        instr_code_next, cur_opcode_next, cur_aux_next);
        default:
          fin_v = 1'b0;
      endcase
    end

    // End status.
    err_final           = fin_v ? fin_res.error_code : err_code_next;
    failed_final        = failed_next || fin_v;
    end_res             = '0;
    end_res.kind        = bif_pkg::KIND_END;
    end_res.error_code  = err_final;
    end_res.success     = !failed_final || (allow_partial && any_emitted_next);
    end_res.file_offset = byte_position_next;

    // The file is done: the next item starts a new one.
    if (in_q.end_of_file) begin
      byte_position_next      = '0;
      phase_next              = bif_pkg::PH_FIRST;
      header_seen_next        = 1'b0;
      bad_header_pending_next = 1'b0;
      instr_start_next        = '0;
      instr_code_next         = '0;
      cur_opcode_next         = '0;
      cur_aux_next            = '0;
      operand_needed_next     = '0;
      operand_count_next      = '0;
      operand_shift_next      = '0;
      failed_next             = 1'b0;
      any_emitted_next        = 1'b0;
      err_code_next           = bif_pkg::ERR_NONE;
    end

    // A consumed-byte result and a truncation error never occur together,
    // so the end status is always the second of two results.
    n_res    = {1'b0, cons_v} + {1'b0, fin_v} + {1'b0, in_q.end_of_file};
    wr.count = fire ? n_res : 2'd0;
    wr.slot0 = cons_v ? cons_res : (fin_v ? fin_res : end_res);
    wr.slot0.last_of_run = (n_res == 2'd1);
    wr.slot1 = end_res;
    wr.slot1.last_of_run = 1'b1;
  end

  // State update on every parsed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      phase              <= bif_pkg::PH_FIRST;
      header_seen        <= 1'b0;
      bad_header_pending <= 1'b0;
      failed             <= 1'b0;
      any_emitted        <= 1'b0;
      err_code           <= bif_pkg::ERR_NONE;
    end else if (fire) begin
      byte_position      <= byte_position_next;
      phase              <= phase_next;
      header_seen        <= header_seen_next;
      bad_header_pending <= bad_header_pending_next;
      failed             <= failed_next;
      any_emitted        <= any_emitted_next;
      err_code           <= err_code_next;
    end
    if (fire) begin
      instr_start    <= instr_start_next;
      instr_code     <= instr_code_next;
      cur_opcode     <= cur_opcode_next;
      cur_aux        <= cur_aux_next;
      operand_needed <= operand_needed_next;
      operand_count  <= operand_count_next;
      operand_shift  <= operand_shift_next;
    end
  end

`include "bytecode_instruction_framer_assert.svh"

  `BIF_ASSERT_SAME(a_failed_has_code, failed, err_code != bif_pkg::ERR_NONE)
  `BIF_ASSERT_NEXT(a_eof_clears, fire && in_q.end_of_file,
                   byte_position == '0 && phase == bif_pkg::PH_FIRST && !failed)
  `BIF_ASSERT_SAME(a_second_is_end, wr.count == 2'd2, wr.slot1.kind == bif_pkg::KIND_END)

endmodule

### hdl/bif_result_queue.sv
module bif_result_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  bif_pkg::queue_wr_t  wr,
  output logic                room,
  bif_result_if.source        result
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bif_pkg::result_t mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [PW-1:0]    idx1, idx2;
  logic [CW-1:0]    count;
  logic             pop;
  bif_pkg::result_t head;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] v);
    return (v == PW'(DEPTH - 1)) ? '0 : v + 1'b1;
  endfunction

  assign idx1 = wrap_inc(wr_ptr);
  assign idx2 = wrap_inc(idx1);
  assign room = count <= CW'(DEPTH - 2);
  assign pop  = result.valid && result.ready;
  assign head = mem[rd_ptr];

  // Storage: up to two writes per cycle at consecutive slots.
  always_ff @(posedge clk) begin
    if (wr.count != 2'd0) mem[wr_ptr] <= wr.slot0;
    if (wr.count == 2'd2) mem[idx1] <= wr.slot1;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.count == 2'd1) wr_ptr <= idx1;
      else if (wr.count == 2'd2) wr_ptr <= idx2;
      if (pop) rd_ptr <= wrap_inc(rd_ptr);
      count <= count + CW'(wr.count) - CW'(pop);
    end
  end

  // Head of the queue drives the result channel.
  assign result.valid          = count != '0;
  assign result.kind           = head.kind;
  assign result.error_code     = head.error_code;
  assign result.success        = head.success;
  assign result.file_offset    = head.file_offset;
  assign result.code_offset    = head.code_offset;
  assign result.opcode         = head.opcode;
  assign result.aux            = head.aux;
  assign result.extra_len      = head.extra_len;
  assign result.operand_first  = head.operand_first;
  assign result.operand_second = head.operand_second;
  assign result.jump_target    = head.jump_target;
  assign result.last_of_run    = head.last_of_run;

`include "bytecode_instruction_framer_assert.svh"

  `BIF_ASSERT_SAME(a_count_bound, 1'b1, count <= CW'(DEPTH))
  `BIF_ASSERT_SAME(a_write_fits, wr.count != 2'd0,
                   ({1'b0, count} + (CW + 1)'(wr.count)) <= (CW + 1)'(DEPTH))
  `BIF_ASSERT_NEXT(a_pop_only, pop && wr.count == 2'd0, count == $past(count) - 1'b1)

endmodule
